// ----- design/bds2_pkg.sv -----
// ----------------------------------------------------------------------------
// bds2_pkg: shared constants and helpers of the 2x2 box downsampler
// Holds the image limits, the field widths, the register indexes and the
// functions that bound the configuration registers.
// ----------------------------------------------------------------------------
package bds2_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int MAX_CHANNELS = 4;
   localparam int SAMPLE_BITS  = 16;
   localparam int PAIR_BITS    = SAMPLE_BITS + 1;
   localparam int OUT_BITS     = SAMPLE_BITS + 2;

   localparam int LINE_DEPTH   = (MAX_WIDTH / 2) * MAX_CHANNELS;
   localparam int LINE_AW      = $clog2(LINE_DEPTH);

   localparam int DIM_BITS     = 11;                  // register width of width/height
   localparam int CHN_BITS     = 3;                   // register width of channel count
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
   localparam int CIX_BITS     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int HALF_BITS    = COL_BITS - 1;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = DIM_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_CHANNEL_COUNT = 2'd2
   } csr_index_type;

   // Zero acts as one, anything above the limit acts as the limit.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CHN_BITS-1:0] clamp_chn(input logic [CHN_BITS-1:0] v);
      logic [CHN_BITS-1:0] r;
      if (v == '0) begin
         r = CHN_BITS'(1);
      end else if (v > CHN_BITS'(MAX_CHANNELS)) begin
         r = CHN_BITS'(MAX_CHANNELS);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- design/bds2_ram.sv -----
// ----------------------------------------------------------------------------
// bds2_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module bds2_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/box_downsample_2x2_core.sv -----
// ----------------------------------------------------------------------------
// box_downsample_2x2_core: streaming 2x2 box-filter downsampler
// Sums every 2x2 block of same-channel samples of a raster, channel-
// interleaved image into one output sample (average with 2 fraction bits).
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  req_sample (s16)
//   rsp_      out         rsp_valid / rsp_stall  rsp_average (s18), rsp_last_of_image
//   csr_      in          csr_valid / csr_ready  csr_index, csr_data
//
// The block takes one sample per clock while req_stall is low. An item that
// completes a 2x2 block issues its line-store read at acceptance; the sum
// then passes the read stage and the output register to the rsp_ side.
// Reset returns the registers to 640 x 480 with one channel and restarts the
// image; the line store and the pair registers are not cleared, since every
// entry is written on an even row before the odd row reads it.
// A stalled output holds one finished item while one more waits in the read
// stage; only when both are full is req_stall raised.
// ----------------------------------------------------------------------------
module box_downsample_2x2_core
   import bds2_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_BITS-1:0]    rsp_average,
   output logic                          rsp_last_of_image,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   // Configuration registers, stored raw as written and bounded on use.
   logic [DIM_BITS-1:0] width_ff,  width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [CHN_BITS-1:0] chans_ff,  chans_in;

   // Position in the image.
   logic [COL_BITS-1:0] column_count_ff,  column_count_in;
   logic [ROW_BITS-1:0] row_count_ff,     row_count_in;
   logic [CIX_BITS-1:0] channel_index_ff, channel_index_in;

   // First sample of each channel's horizontal pair.
   logic signed [SAMPLE_BITS-1:0] pair_ff [MAX_CHANNELS];

   // Read stage: pair sum waiting for the line-store data.
   logic                        s1_valid_ff, s1_valid_in;
   logic signed [PAIR_BITS-1:0] s1_pair_ff;
   logic                        s1_last_ff;

   // Output register.
   logic                       out_valid_ff, out_valid_in;
   logic signed [OUT_BITS-1:0] out_average_ff;
   logic                       out_last_ff;

   logic [DIM_BITS-1:0] w_eff, h_eff, w_even, h_even;
   logic [CHN_BITS-1:0] nc_eff;
   logic                accept, csr_write;
   logic                in_block, x_odd, y_odd;
   logic                line_wr, line_rd;
   logic [LINE_AW-1:0]  line_idx;
   logic signed [PAIR_BITS-1:0] pair_total;
   logic [PAIR_BITS-1:0]        line_rd_data;
   logic                        last_hit;
   logic                        s1_move, out_free;
   logic [CHN_BITS-1:0]         c_next;
   logic [DIM_BITS-1:0]         x_next, y_next;
   logic signed [OUT_BITS-1:0]  block_sum;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign w_eff  = clamp_dim(width_ff,  DIM_BITS'(MAX_WIDTH));
   assign h_eff  = clamp_dim(height_ff, DIM_BITS'(MAX_HEIGHT));
   assign nc_eff = clamp_chn(chans_ff);
   assign w_even = {w_eff[DIM_BITS-1:1], 1'b0};
   assign h_even = {h_eff[DIM_BITS-1:1], 1'b0};

   // Handshake: the output register frees when taken; the read stage moves
   // into it when it is free. A new item may enter whenever the read stage
   // is empty or moving on.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign x_odd    = column_count_ff[0];
   assign y_odd    = row_count_ff[0];
   assign in_block = (DIM_BITS'(column_count_ff) < w_even) &&
                     (DIM_BITS'(row_count_ff) < h_even);

   // Line entry of this pair: (x/2) * channels + channel.
   assign line_idx = LINE_AW'(column_count_ff[COL_BITS-1:1]) * LINE_AW'(nc_eff) +
                     LINE_AW'(channel_index_ff);

   assign pair_total = PAIR_BITS'(pair_ff[channel_index_ff]) + PAIR_BITS'(req_sample);

   assign line_wr = accept && in_block && x_odd && !y_odd;
   assign line_rd = accept && in_block && x_odd && y_odd;

   assign last_hit = (DIM_BITS'(row_count_ff) == h_even - DIM_BITS'(1)) &&
                     (DIM_BITS'(column_count_ff) == w_even - DIM_BITS'(1)) &&
                     (CHN_BITS'(channel_index_ff) == nc_eff - CHN_BITS'(1));

   bds2_ram #(
      .WIDTH (PAIR_BITS),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (line_idx),
      .wr_data (pair_total),
      .rd_en   (line_rd),
      .rd_addr (line_idx),
      .rd_data (line_rd_data)
   );

   assign block_sum = OUT_BITS'(signed'(line_rd_data)) + OUT_BITS'(s1_pair_ff);

   // Position stepping and configuration writes.
   always_comb begin
      width_in         = width_ff;
      height_in        = height_ff;
      chans_in         = chans_ff;
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      channel_index_in = channel_index_ff;
      c_next = CHN_BITS'(channel_index_ff) + CHN_BITS'(1);
      x_next = DIM_BITS'(column_count_ff) + DIM_BITS'(1);
      y_next = DIM_BITS'(row_count_ff) + DIM_BITS'(1);

      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   width_in  = csr_data;
            REG_IMAGE_HEIGHT:  height_in = csr_data;
            REG_CHANNEL_COUNT: chans_in  = csr_data[CHN_BITS-1:0];
            default: ;
         endcase
         if (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT ||
             csr_index == REG_CHANNEL_COUNT) begin
            column_count_in  = '0;
            row_count_in     = '0;
            channel_index_in = '0;
         end
      end else if (accept) begin
         if (c_next >= nc_eff) begin
            channel_index_in = '0;
            if (x_next >= w_eff) begin
               column_count_in = '0;
               if (y_next >= h_eff) begin
                  row_count_in = '0;
               end else begin
                  row_count_in = y_next[ROW_BITS-1:0];
               end
            end else begin
               column_count_in = x_next[COL_BITS-1:0];
            end
         end else begin
            channel_index_in = c_next[CIX_BITS-1:0];
         end
      end
   end

   always_comb begin
      s1_valid_in = (s1_valid_ff && !s1_move) || line_rd;
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff         <= DIM_BITS'(640);
         height_ff        <= DIM_BITS'(480);
         chans_ff         <= CHN_BITS'(1);
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         channel_index_ff <= '0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         width_ff         <= width_in;
         height_ff        <= height_in;
         chans_ff         <= chans_in;
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         channel_index_ff <= channel_index_in;
         s1_valid_ff      <= s1_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept && in_block && !x_odd) begin
         pair_ff[channel_index_ff] <= req_sample;
      end
      if (line_rd) begin
         s1_pair_ff <= pair_total;
         s1_last_ff <= last_hit;
      end
      if (s1_move) begin
         out_average_ff <= block_sum;
         out_last_ff    <= s1_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_average       = out_average_ff;
   assign rsp_last_of_image = out_last_ff;

   // The position always stays inside the configured image.
   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      DIM_BITS'(column_count_ff) < w_eff)
      else $error("column position beyond image width");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      CHN_BITS'(channel_index_ff) < nc_eff)
      else $error("channel index beyond channel count");

   // No new line read while the read stage must hold its RAM data.
   a_no_read_while_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !line_rd)
      else $error("line read would overwrite held read data");

   // A read stage item moving on always lands in the output register.
   a_s1_reaches_output: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid)
      else $error("read stage item lost on its way to the output");

   // Line reads and writes are never both issued in one cycle.
   a_single_line_access: assert property (@(posedge clock) disable iff (reset)
      !(line_rd && line_wr))
      else $error("line store read and write in the same cycle");

endmodule

// ----- dv/box_downsample_2x2_core_test.sv -----
// ----------------------------------------------------------------------------
// box_downsample_2x2_core_test: self-checking bench for the 2x2 box downsampler
// Streams raster images with interleaved channels into the core under random
// idling on both sides. Each 2x2 block sum and end-of-image flag is predicted
// and compared field by field with what the core puts out.
// ----------------------------------------------------------------------------
module box_downsample_2x2_core_test
   import bds2_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 8;      // covers the two-stage read path and then some
   localparam int TAIL_CYCLES   = 16;
   localparam int HOLD_CYCLES   = 200;    // long output hold that backs up the input
   localparam int QUIET_LIMIT   = 1000;   // cycles with no transfer on any channel
   localparam int RANDOM_ITEMS  = 480;
   localparam int WIDE_ITEMS    = 64;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [CSR_DATA_BITS-1:0]      DATA_MAX   = '1;

   // The index after the last register; writes to it must be dropped.
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE = 2'd3;

   // One finished 2x2 block as the core should report it.
   typedef struct {
      logic signed [OUT_BITS-1:0] average;
      logic                       last_of_image;
   } block_sum_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [OUT_BITS-1:0]    rsp_average;
   logic                          rsp_last_of_image;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_BITS-1:0]       csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_data;

   // Shadow copy of the core's registers, scan position and sum stores.
   logic [DIM_BITS-1:0]           width_setting;
   logic [DIM_BITS-1:0]           height_setting;
   logic [CHN_BITS-1:0]           channel_setting;
   logic [COL_BITS-1:0]           col_pos;
   logic [ROW_BITS-1:0]           row_pos;
   logic [CIX_BITS-1:0]           chan_pos;
   logic signed [PAIR_BITS-1:0]   first_of_pair [MAX_CHANNELS];
   logic signed [PAIR_BITS-1:0]   even_row_sums [LINE_DEPTH];

   block_sum_type                 pending_block_sums[$];
   block_sum_type                 oldest_sum;

   int                            mismatch_count = 0;
   int                            items_sent = 0;
   int                            quiet_cycles = 0;
   bit                            tx_steady = 1'b0;
   bit                            rx_steady = 1'b0;
   bit                            hold_requested = 1'b0;

   box_downsample_2x2_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .rsp_last_of_image (rsp_last_of_image),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // A register value of zero behaves as one, and anything above the limit
   // behaves as the limit.
   function automatic int bounded_setting(input int raw, input int limit);
      if (raw == 0) return 1;
      return (raw > limit) ? limit : raw;
   endfunction

   // Advances the shadow scan by one accepted sample. Even columns park the
   // sample, odd columns close a horizontal pair; even rows store the pair,
   // odd rows add it to the stored one and produce a block sum. Samples in
   // a trailing odd column or row only move the position.
   task automatic predict_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int                          w;
      int                          h;
      int                          nc;
      int                          w_even;
      int                          h_even;
      int                          x;
      int                          y;
      int                          c;
      int                          slot;
      logic signed [PAIR_BITS-1:0] pair;
      block_sum_type               block;
      w      = bounded_setting(int'(width_setting), MAX_WIDTH);
      h      = bounded_setting(int'(height_setting), MAX_HEIGHT);
      nc     = bounded_setting(int'(channel_setting), MAX_CHANNELS);
      w_even = w - (w % 2);
      h_even = h - (h % 2);
      x      = int'(col_pos);
      y      = int'(row_pos);
      c      = int'(chan_pos);
      if (x < w_even && y < h_even) begin
         if (x % 2 == 0) begin
            first_of_pair[c] = PAIR_BITS'(value);
         end else begin
            pair = first_of_pair[c] + PAIR_BITS'(value);
            slot = (x / 2) * nc + c;
            if (y % 2 == 0) begin
               even_row_sums[slot] = pair;
            end else begin
               block.average       = OUT_BITS'(even_row_sums[slot]) + OUT_BITS'(pair);
               block.last_of_image = (y == h_even - 1) && (x == w_even - 1) && (c == nc - 1);
               pending_block_sums.push_back(block);
            end
         end
      end
      c++;
      if (c >= nc) begin
         c = 0;
         x++;
         if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
         end
      end
      col_pos  = COL_BITS'(x);
      row_pos  = ROW_BITS'(y);
      chan_pos = CIX_BITS'(c);
   endtask

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------

   // Writes one register. Any write to a real register restarts the image
   // at column 0, row 0, channel 0; the spare index changes nothing.
   task automatic write_register(input logic [CSR_IDX_BITS-1:0]  index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      bit restart;
      restart = 1'b1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         REG_IMAGE_WIDTH:   width_setting   = value;
         REG_IMAGE_HEIGHT:  height_setting  = value;
         REG_CHANNEL_COUNT: channel_setting = value[CHN_BITS-1:0];
         default:           restart         = 1'b0;
      endcase
      if (restart) begin
         col_pos  = '0;
         row_pos  = '0;
         chan_pos = '0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offers one item after a random gap and returns at the edge where the
   // core takes it. Valid stays high into the next call when that call
   // draws no gap, so back-to-back items stream at full rate.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sample(value);
      items_sent++;
   endtask

   // Closes a phase: drops valid, waits for every predicted block sum, then
   // lets the read path empty out before registers may be touched again.
   task automatic finish_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_block_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly full-range random samples, with the two extremes mixed in often
   // enough that block sums reach both ends of the output range.
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // The receiver draws a stall length per item. A hold request from a test
   // makes it stall for a long stretch first, so the core's output and read
   // stages fill up and req_stall has to rise.
   initial begin
      int pause;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         pause = rx_steady ? 0 : $urandom_range(0, 10);
         if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_block_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected item: average %0d last_of_image %0b",
                                      rsp_average, rsp_last_of_image));
         end else begin
            oldest_sum = pending_block_sums.pop_front();
            if (rsp_average !== oldest_sum.average)
               report_mismatch($sformatf("average %0d, predicted %0d",
                                         rsp_average, oldest_sum.average));
            if (rsp_last_of_image !== oldest_sum.last_of_image)
               report_mismatch($sformatf("last_of_image %b, predicted %b",
                                         rsp_last_of_image, oldest_sum.last_of_image));
         end
      end
   end

   // Watchdog: a correct run never goes this long without some transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Only the width is written, so height and channel count keep their reset
   // values. Four rows of two columns give two blocks, one all minimum and
   // one all maximum; neither ends the image since 480 rows are expected.
   task automatic test_reset_defaults();
      write_register(REG_IMAGE_WIDTH, CSR_DATA_BITS'(2));
      repeat (4) send_sample(SAMPLE_MIN);
      repeat (4) send_sample(SAMPLE_MAX);
      finish_phase();
   endtask

   // A 3x3 single-channel image: the third column and the third row are
   // consumed without output, and the one block left closes the image.
   task automatic test_odd_edges_dropped();
      logic signed [SAMPLE_BITS-1:0] pattern [9];
      pattern = '{16'sh5555, -16'sh5556, 16'sh7FFF, 16'sh0001, -16'sh0001,
                  16'sh1234, -16'sh8000, 16'sh0F0F, 16'sh0000};
      write_register(REG_IMAGE_WIDTH, CSR_DATA_BITS'(3));
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(3));
      foreach (pattern[i]) send_sample(pattern[i]);
      finish_phase();
   endtask

   // Zero in every register acts as a 1x1 single-channel image, which has
   // no complete block and so never produces anything.
   task automatic test_zero_registers();
      write_register(REG_IMAGE_WIDTH, CSR_DATA_BITS'(0));
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(0));
      write_register(REG_CHANNEL_COUNT, CSR_DATA_BITS'(0));
      repeat (4) send_sample(random_sample());
      finish_phase();
   endtask

   // A write to the spare index in the middle of a 2x2 image must neither
   // take effect nor restart the image: the second row still completes it.
   task automatic test_spare_index_ignored();
      write_register(REG_IMAGE_WIDTH, CSR_DATA_BITS'(2));
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(2));
      write_register(REG_CHANNEL_COUNT, CSR_DATA_BITS'(1));
      repeat (2) send_sample(random_sample());
      finish_phase();
      write_register(REG_SPARE, DATA_MAX);
      repeat (2) send_sample(random_sample());
      finish_phase();
   endtask

   // The receiver holds off for a long stretch while the sender streams a
   // two-channel image at full rate, so the core must stall its input and
   // then resume without losing or repeating an item.
   task automatic test_output_hold();
      write_register(REG_IMAGE_WIDTH, CSR_DATA_BITS'(8));
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(4));
      write_register(REG_CHANNEL_COUNT, CSR_DATA_BITS'(2));
      hold_requested = 1'b1;
      tx_steady      = 1'b1;
      repeat (8 * 4 * 2) send_sample(random_sample());
      finish_phase();
   endtask

   // The largest width register value saturates to the widest row. The start
   // of that row with four channels is all even-row work and gives nothing.
   // The width is then set back to a small value so later phases stay short.
   task automatic test_widest_row();
      write_register(REG_IMAGE_WIDTH, DATA_MAX);
      write_register(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(3));
      write_register(REG_CHANNEL_COUNT, CSR_DATA_BITS'(4));
      repeat (WIDE_ITEMS) send_sample(random_sample());
      finish_phase();
      write_register(REG_IMAGE_WIDTH, CSR_DATA_BITS'(4));
   endtask

   // Random small images. Most phases run whole images so every block and
   // every end-of-image flag is reached; the rest stop mid-image or send a
   // few loose items. Registers are rewritten in random subsets, including
   // zero, saturating values and the spare index; when none is written the
   // next phase simply carries on from where the last one stopped.
   task automatic test_random_images();
      int first_item;
      int raw_width;
      int raw_height;
      int raw_channels;
      int w;
      int h;
      int nc;
      int per_image;
      int count;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       raw_width = 0;
            1:       raw_width = 1;
            default: raw_width = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 9))
            0:       raw_height = 0;
            1:       raw_height = 1;
            2:       raw_height = $urandom_range(MAX_HEIGHT + 1, int'(DATA_MAX));
            default: raw_height = $urandom_range(2, 6);
         endcase
         raw_channels = $urandom_range(0, 7);
         if ($urandom_range(0, 3) != 0)
            write_register(REG_IMAGE_WIDTH, CSR_DATA_BITS'(raw_width));
         if ($urandom_range(0, 3) != 0)
            write_register(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(raw_height));
         if ($urandom_range(0, 3) != 0)
            write_register(REG_CHANNEL_COUNT, CSR_DATA_BITS'(raw_channels));
         if ($urandom_range(0, 7) == 0) write_register(REG_SPARE, CSR_DATA_BITS'($urandom));

         w  = bounded_setting(int'(width_setting), MAX_WIDTH);
         h  = bounded_setting(int'(height_setting), MAX_HEIGHT);
         nc = bounded_setting(int'(channel_setting), MAX_CHANNELS);
         // Tall images never finish in a phase; two row pairs are plenty.
         per_image = w * ((h > 6) ? 4 : h) * nc;
         case ($urandom_range(0, 7))
            0:       count = $urandom_range(1, per_image);
            1:       count = $urandom_range(1, 20);
            default: count = per_image * $urandom_range(1, 2);
         endcase
         repeat (count) send_sample(random_sample());
         finish_phase();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;

      // Shadow state after reset: 640 x 480, one channel, image start.
      // The stores are never read before being written, so zero is as good
      // as any value there.
      width_setting   = DIM_BITS'(640);
      height_setting  = DIM_BITS'(480);
      channel_setting = CHN_BITS'(1);
      col_pos         = '0;
      row_pos         = '0;
      chan_pos        = '0;
      foreach (first_of_pair[i]) first_of_pair[i] = '0;
      foreach (even_row_sums[i]) even_row_sums[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_odd_edges_dropped();
      test_zero_registers();
      test_spare_index_ignored();
      test_output_hold();
      test_widest_row();
      test_random_images();

      // All predictions have been met by now; give the core a few more
      // cycles to show any stray output.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
